### rtl/mht_pkg.sv
// ----------------------------------------------------------------------------
// mht_pkg: shared definitions for the masked histogram threshold block
// Sizes, command codes, the queued item format and the back-end states.
// ----------------------------------------------------------------------------
package mht_pkg;

  // Grey level width (8..16), coarse bin width (4..8) and count width (16..32).
  localparam int PixelBits  = 16;
  localparam int CoarseBits = 8;
  localparam int CountBits  = 32;

  localparam int FineDepth   = 2 ** PixelBits;
  localparam int CoarseDepth = 2 ** CoarseBits;

  // Queue between the front and back parts; the depth must be a power of two.
  localparam int QueueDepth = 4;
  localparam int QPtrBits   = $clog2(QueueDepth);

  localparam logic [7:0] FullMask   = 8'hFF;
  localparam logic [7:0] Foreground = 8'hFF;
  localparam logic [7:0] Background = 8'h00;

  typedef enum logic [1:0] {
    CMD_ACCUMULATE = 2'd0,
    CMD_THRESHOLD  = 2'd1,
    CMD_READ       = 2'd2,
    CMD_CLEAR      = 2'd3
  } cmd_e;

  // Configuration register index, taken from the word address.
  typedef enum logic {
    REG_EDGE_LEVEL = 1'b0,
    REG_UNUSED     = 1'b1
  } reg_e;

  typedef enum logic {
    BS_RUN   = 1'b0,
    BS_SWEEP = 1'b1
  } back_state_e;

  typedef struct packed {
    cmd_e                  op;
    logic [PixelBits-1:0]  fine_addr;
    logic [CoarseBits-1:0] coarse_addr;
    logic                  fg;
  } item_t;

endpackage

### rtl/mht_ram.sv
// ----------------------------------------------------------------------------
// mht_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered and returns
// the contents from before a write to the same address in the same cycle.
// ----------------------------------------------------------------------------
module mht_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/mht_front.sv
// ----------------------------------------------------------------------------
// mht_front: command decode and item queue
// Classifies each accepted transaction, drops unmasked accumulations, works out
// the threshold decision and queues the rest for the back end.
// ----------------------------------------------------------------------------
module mht_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [1:0]           command_i,
  input  logic [15:0]          pixel_value_i,
  input  logic [7:0]           mask_value_i,
  input  logic [15:0]          fine_index_i,
  input  logic [7:0]           coarse_index_i,
  input  logic [15:0]          edge_level_i,
  output logic                 full_o,
  output mht_pkg::item_t       head_o,
  output logic                 head_valid_o,
  input  logic                 pop_i
);

  mht_pkg::item_t                  item;
  logic                            keep;
  logic                            mask_full;
  logic [mht_pkg::PixelBits-1:0]   pix;
  logic [mht_pkg::PixelBits-1:0]   edge_lvl;

  mht_pkg::item_t                  q_mem_q [mht_pkg::QueueDepth];
  logic [mht_pkg::QPtrBits-1:0]    wr_ptr_q, wr_ptr_d;
  logic [mht_pkg::QPtrBits-1:0]    rd_ptr_q, rd_ptr_d;
  logic [mht_pkg::QPtrBits:0]      count_q, count_d;
  logic                            push;

  always_comb begin
    pix       = pixel_value_i[mht_pkg::PixelBits-1:0];
    edge_lvl  = edge_level_i[mht_pkg::PixelBits-1:0];
    mask_full = (mask_value_i == mht_pkg::FullMask);
    item.op   = mht_pkg::cmd_e'(command_i);
    item.fg   = mask_full && (pix >= edge_lvl);
    keep      = 1'b1;
    case (mht_pkg::cmd_e'(command_i))
      mht_pkg::CMD_READ: begin
        item.fine_addr   = fine_index_i[mht_pkg::PixelBits-1:0];
        item.coarse_addr = coarse_index_i[mht_pkg::CoarseBits-1:0];
      end
      mht_pkg::CMD_ACCUMULATE: begin
        item.fine_addr   = pix;
        item.coarse_addr = pix[mht_pkg::PixelBits-1 -: mht_pkg::CoarseBits];
        keep             = mask_full;
      end
      default: begin
        item.fine_addr   = pix;
        item.coarse_addr = pix[mht_pkg::PixelBits-1 -: mht_pkg::CoarseBits];
      end
    endcase
  end

  assign push         = accept_i && keep;
  assign full_o       = (count_q == (mht_pkg::QPtrBits+1)'(mht_pkg::QueueDepth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = q_mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= item;
    end
  end

endmodule

### rtl/mht_back.sv
// ----------------------------------------------------------------------------
// mht_back: histogram stores and result generation
// Issues bin reads from the queue head, updates saturating counts with
// forwarding of the previous write, and sweeps both stores on reset or clear.
// ----------------------------------------------------------------------------
module mht_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mht_pkg::item_t        head_i,
  input  logic                  head_valid_i,
  output logic                  pop_o,
  output logic                  init_busy_o,
  output logic                  done_o,
  output logic [7:0]            binary_pixel_o,
  output logic [31:0]           fine_count_o,
  output logic [31:0]           coarse_count_o
);

  localparam int PB = mht_pkg::PixelBits;
  localparam int CB = mht_pkg::CoarseBits;
  localparam int NB = mht_pkg::CountBits;

  function automatic logic [NB-1:0] bump(input logic [NB-1:0] c);
    bump = (c == '1) ? c : c + 1'b1;
  endfunction

  mht_pkg::back_state_e state_q, state_d;
  logic [PB-1:0]        sweep_cnt_q, sweep_cnt_d;
  logic                 init_q, init_d;

  logic                 b_valid_q;
  mht_pkg::item_t       b_item_q;

  logic                 fwd_valid_q;
  logic [PB-1:0]        fwd_fine_addr_q;
  logic [CB-1:0]        fwd_coarse_addr_q;
  logic [NB-1:0]        fwd_fine_q;
  logic [NB-1:0]        fwd_coarse_q;

  logic                 issue;
  logic                 sweeping;
  logic                 acc_wr;
  logic [NB-1:0]        fine_rdata, coarse_rdata;
  logic [NB-1:0]        fine_cur, coarse_cur;
  logic [NB-1:0]        fine_next, coarse_next;

  logic                 fine_we;
  logic [PB-1:0]        fine_waddr;
  logic [NB-1:0]        fine_wdata;
  logic [CB-1:0]        coarse_waddr;
  logic [NB-1:0]        coarse_wdata;

  logic                 done_q;
  logic [7:0]           binary_q;
  logic [NB-1:0]        fine_out_q, coarse_out_q;

  assign sweeping = (state_q == mht_pkg::BS_SWEEP);
  // A clear in the second stage holds issue back until its sweep has run.
  assign issue    = head_valid_i && !sweeping &&
                    !(b_valid_q && (b_item_q.op == mht_pkg::CMD_CLEAR));
  assign pop_o    = issue;
  assign acc_wr   = b_valid_q && (b_item_q.op == mht_pkg::CMD_ACCUMULATE);

  // The read was registered at the edge of the previous write; take that
  // value where the addresses match.
  assign fine_cur   = (fwd_valid_q && (fwd_fine_addr_q == b_item_q.fine_addr))
                      ? fwd_fine_q : fine_rdata;
  assign coarse_cur = (fwd_valid_q && (fwd_coarse_addr_q == b_item_q.coarse_addr))
                      ? fwd_coarse_q : coarse_rdata;
  assign fine_next   = bump(fine_cur);
  assign coarse_next = bump(coarse_cur);

  assign fine_we      = acc_wr || sweeping;
  assign fine_waddr   = sweeping ? sweep_cnt_q : b_item_q.fine_addr;
  assign fine_wdata   = sweeping ? '0 : fine_next;
  assign coarse_waddr = sweeping ? sweep_cnt_q[CB-1:0] : b_item_q.coarse_addr;
  assign coarse_wdata = sweeping ? '0 : coarse_next;

  mht_ram #(
    .Width (NB),
    .Depth (mht_pkg::FineDepth)
  ) u_fine_ram (
    .clk_i   (clk_i),
    .we_i    (fine_we),
    .waddr_i (fine_waddr),
    .wdata_i (fine_wdata),
    .re_i    (issue),
    .raddr_i (head_i.fine_addr),
    .rdata_o (fine_rdata)
  );

  mht_ram #(
    .Width (NB),
    .Depth (mht_pkg::CoarseDepth)
  ) u_coarse_ram (
    .clk_i   (clk_i),
    .we_i    (fine_we),
    .waddr_i (coarse_waddr),
    .wdata_i (coarse_wdata),
    .re_i    (issue),
    .raddr_i (head_i.coarse_addr),
    .rdata_o (coarse_rdata)
  );

  always_comb begin
    state_d     = state_q;
    sweep_cnt_d = sweep_cnt_q;
    init_d      = init_q;
    case (state_q)
      mht_pkg::BS_RUN: begin
        if (b_valid_q && (b_item_q.op == mht_pkg::CMD_CLEAR)) begin
          state_d     = mht_pkg::BS_SWEEP;
          sweep_cnt_d = '0;
        end
      end
      mht_pkg::BS_SWEEP: begin
        sweep_cnt_d = sweep_cnt_q + 1'b1;
        if (sweep_cnt_q == '1) begin
          state_d = mht_pkg::BS_RUN;
          init_d  = 1'b0;
        end
      end
      default: begin
        state_d = mht_pkg::BS_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mht_pkg::BS_SWEEP;
      sweep_cnt_q <= '0;
      init_q      <= 1'b1;
      b_valid_q   <= 1'b0;
      fwd_valid_q <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_cnt_q <= sweep_cnt_d;
      init_q      <= init_d;
      b_valid_q   <= issue;
      fwd_valid_q <= acc_wr;
      done_q      <= b_valid_q && ((b_item_q.op == mht_pkg::CMD_THRESHOLD) ||
                                   (b_item_q.op == mht_pkg::CMD_READ));
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      b_item_q <= head_i;
    end
    fwd_fine_addr_q   <= b_item_q.fine_addr;
    fwd_coarse_addr_q <= b_item_q.coarse_addr;
    fwd_fine_q        <= fine_next;
    fwd_coarse_q      <= coarse_next;
    if (b_item_q.op == mht_pkg::CMD_READ) begin
      binary_q     <= mht_pkg::Background;
      fine_out_q   <= fine_cur;
      coarse_out_q <= coarse_cur;
    end else begin
      binary_q     <= b_item_q.fg ? mht_pkg::Foreground : mht_pkg::Background;
      fine_out_q   <= '0;
      coarse_out_q <= '0;
    end
  end

  assign init_busy_o    = init_q;
  assign done_o         = done_q;
  assign binary_pixel_o = binary_q;
  assign fine_count_o   = 32'(fine_out_q);
  assign coarse_count_o = 32'(coarse_out_q);

endmodule

### rtl/masked_histogram_threshold.sv
// ----------------------------------------------------------------------------
// masked_histogram_threshold: masked fine and coarse histogram with threshold
// Counts masked grey pixels into two saturating histograms, thresholds pixels
// against a programmable edge level and reads bin pairs back on command.
// ----------------------------------------------------------------------------
// Result path: an accepted transaction is queued, passes through the back-end
// stage and is then registered onto done_o and the result fields; items queued
// ahead of it delay it. Throughput: one transaction per cycle while busy is
// low, set by the one read and one write port of each histogram memory. A
// clear occupies the back end while it sweeps the fine store, one entry per
// cycle. Reset: the same sweep runs with busy high; results cannot be stalled.
// ----------------------------------------------------------------------------
module masked_histogram_threshold (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Command channel
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command_i,
  input  logic [15:0] pixel_value_i,
  input  logic [7:0]  mask_value_i,
  input  logic [15:0] fine_index_i,
  input  logic [7:0]  coarse_index_i,
  // Result channel
  output logic        done_o,
  output logic [7:0]  binary_pixel_o,
  output logic [31:0] fine_count_o,
  output logic [31:0] coarse_count_o,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0]    edge_level_q;
  logic           cfg_write;
  mht_pkg::reg_e  reg_sel;

  logic           accept;
  logic           queue_full;
  logic           init_busy;
  mht_pkg::item_t head;
  logic           head_valid;
  logic           pop;

  // The configuration port completes every access in its access cycle. Only
  // the edge level register exists; writes to the word above it are dropped
  // and read back as zero.
  assign pready    = 1'b1;
  assign reg_sel   = mht_pkg::reg_e'(paddr[2]);
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_level_q <= '0;
    end else if (cfg_write && (reg_sel == mht_pkg::REG_EDGE_LEVEL)) begin
      edge_level_q <= pwdata[15:0];
    end
  end

  assign prdata = (reg_sel == mht_pkg::REG_EDGE_LEVEL) ? 32'(edge_level_q) : '0;

  // New transactions are refused while the queue is full or while the stores
  // are still being cleared after reset. A clear command mid-stream leaves the
  // queue open, so the front keeps filling while the back end sweeps.
  assign busy   = queue_full || init_busy;
  assign accept = start && !busy;

  mht_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .command_i      (command_i),
    .pixel_value_i  (pixel_value_i),
    .mask_value_i   (mask_value_i),
    .fine_index_i   (fine_index_i),
    .coarse_index_i (coarse_index_i),
    .edge_level_i   (edge_level_q),
    .full_o         (queue_full),
    .head_o         (head),
    .head_valid_o   (head_valid),
    .pop_i          (pop)
  );

  // The back end performs a read-modify-write of both histograms per
  // accumulation; a write to the bin just read is forwarded so that a run of
  // equal pixels still advances by one per cycle.
  mht_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .head_valid_i   (head_valid),
    .pop_o          (pop),
    .init_busy_o    (init_busy),
    .done_o         (done_o),
    .binary_pixel_o (binary_pixel_o),
    .fine_count_o   (fine_count_o),
    .coarse_count_o (coarse_count_o)
  );

endmodule

### rtl/mht_checker.sv
// ----------------------------------------------------------------------------
// mht_checker: port-level checks for the masked histogram threshold block
// Watches the result strobe, the result fields and busy around reset.
// ----------------------------------------------------------------------------
module mht_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        busy,
  input logic        done_o,
  input logic [7:0]  binary_pixel_o,
  input logic [31:0] fine_count_o,
  input logic [31:0] coarse_count_o
);

  // A strobed binary value is either foreground or background.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (binary_pixel_o == mht_pkg::Foreground) ||
               (binary_pixel_o == mht_pkg::Background))
    else $error("binary pixel is neither foreground nor background");

  // A foreground threshold transaction carries no counts.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (binary_pixel_o != mht_pkg::Background)) |->
      (fine_count_o == '0) && (coarse_count_o == '0))
    else $error("threshold transaction carries non-zero counts");

  // No result is strobed while reset is held.
  assert property (@(posedge clk_i) !rst_ni |-> !done_o)
    else $error("result strobed during reset");

  // The stores are still being swept just after reset, so nothing is taken.
  assert property (@(posedge clk_i) $rose(rst_ni) |-> busy)
    else $error("transaction possible before the clearing sweep");

  // Nothing can have completed while the reset sweep still holds busy high.
  assert property (@(posedge clk_i) $rose(rst_ni) |-> ##3 !done_o)
    else $error("result strobed right after reset");

endmodule

bind masked_histogram_threshold mht_checker u_mht_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .busy           (busy),
  .done_o         (done_o),
  .binary_pixel_o (binary_pixel_o),
  .fine_count_o   (fine_count_o),
  .coarse_count_o (coarse_count_o)
);

### tb/tb_masked_histogram_threshold.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_masked_histogram_threshold: self-checking bench for the histogram block
// Sends command transactions with random gaps and bursts, keeps its own copy
// of both histograms and of the edge level, and compares every strobed result
// field by field with the predicted one. Short directed tests come first, then
// a long random run split into phases with different edge levels.
// ----------------------------------------------------------------------------
module tb_masked_histogram_threshold;
  import mht_pkg::*;

  localparam int ClkHalf         = 2;
  localparam int ResetCycles     = 12;
  localparam int RandomPhases    = 5;
  localparam int PhaseItems      = 346;
  localparam int MaxRandomClears = 4;
  // Allowance for the result path and the queue to drain, with some margin.
  localparam int DrainCycles     = 16;

  // The register index sits in the word address, so byte address 4 * index.
  localparam logic [2:0] EdgeAddr   = {REG_EDGE_LEVEL, 2'b00};
  localparam logic [2:0] UnusedAddr = {REG_UNUSED, 2'b00};

  typedef struct packed {
    logic [7:0]           binary_pixel;
    logic [CountBits-1:0] fine_count;
    logic [CountBits-1:0] coarse_count;
  } readout_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [1:0]  command_i;
  logic [15:0] pixel_value_i;
  logic [7:0]  mask_value_i;
  logic [15:0] fine_index_i;
  logic [7:0]  coarse_index_i;
  logic        done_o;
  logic [7:0]  binary_pixel_o;
  logic [31:0] fine_count_o;
  logic [31:0] coarse_count_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Shadow state of the block. The fine store is sparse: an entry that has
  // never been bumped reads as zero.
  logic [CountBits-1:0] fine_bins [logic [PixelBits-1:0]];
  logic [CountBits-1:0] coarse_bins [CoarseDepth];
  logic [PixelBits-1:0] edge_model;

  // Results still owed by the block, oldest first.
  readout_t    expected_readouts [$];
  int unsigned fail_count;
  int unsigned clears_left;
  // Upper bound on the cycles left before every accepted clear has swept.
  int unsigned sweep_wait;
  // When set, the sender issues back-to-back transactions with no gaps.
  bit          no_idle;

  masked_histogram_threshold dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .command_i     (command_i),
    .pixel_value_i (pixel_value_i),
    .mask_value_i  (mask_value_i),
    .fine_index_i  (fine_index_i),
    .coarse_index_i(coarse_index_i),
    .done_o        (done_o),
    .binary_pixel_o(binary_pixel_o),
    .fine_count_o  (fine_count_o),
    .coarse_count_o(coarse_count_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #ClkHalf clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  function automatic void wipe_histograms();
    fine_bins.delete();
    foreach (coarse_bins[i]) coarse_bins[i] = '0;
  endfunction

  function automatic logic [CountBits-1:0] fine_bin(logic [PixelBits-1:0] idx);
    return fine_bins.exists(idx) ? fine_bins[idx] : '0;
  endfunction

  // Counts stop at all ones rather than wrapping to zero.
  function automatic logic [CountBits-1:0] saturating_inc(logic [CountBits-1:0] count);
    return (count == '1) ? count : count + 1'b1;
  endfunction

  // Applies one command to the shadow histograms. Returns 1 when the command
  // produces a result, which is then placed in res.
  function automatic bit predict_histogram_op(cmd_e op, logic [PixelBits-1:0] pix,
                                              logic [7:0] mask,
                                              logic [PixelBits-1:0] fidx,
                                              logic [CoarseBits-1:0] cidx,
                                              output readout_t res);
    logic [CoarseBits-1:0] cbin;
    cbin = pix[PixelBits-1 -: CoarseBits];
    res  = '0;
    case (op)
      CMD_ACCUMULATE: begin
        // Only pixels fully inside the region are counted.
        if (mask == FullMask) begin
          fine_bins[pix]    = saturating_inc(fine_bin(pix));
          coarse_bins[cbin] = saturating_inc(coarse_bins[cbin]);
        end
        return 1'b0;
      end
      CMD_THRESHOLD: begin
        res.binary_pixel = (mask == FullMask && pix >= edge_model) ? Foreground : Background;
        return 1'b1;
      end
      CMD_READ: begin
        res.fine_count   = fine_bin(fidx);
        res.coarse_count = coarse_bins[cidx];
        return 1'b1;
      end
      default: begin
        wipe_histograms();
        return 1'b0;
      end
    endcase
  endfunction

  function automatic void flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t ns: %s expected %0h, got %0h", $time, what, want, got);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: everything is sampled at the rising edge, before the block's own
  // registers update, so the values seen are those of the cycle just ending.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    readout_t want;
    readout_t got;
    if (rst_ni) begin
      if (sweep_wait != 0) begin
        sweep_wait--;
      end
      // A strobed result is compared with the oldest outstanding expectation.
      if (done_o) begin
        got = {binary_pixel_o, fine_count_o, coarse_count_o};
        if (expected_readouts.size() == 0) begin
          fail_count++;
          $display("%0t ns: result expected none, got %h", $time, got);
        end else begin
          want = expected_readouts.pop_front();
          flag_mismatch("binary_pixel", want.binary_pixel, got.binary_pixel);
          flag_mismatch("fine_count", want.fine_count, got.fine_count);
          flag_mismatch("coarse_count", want.coarse_count, got.coarse_count);
        end
      end
      // An accepted transaction updates the shadow state straight away.
      if (start && !busy) begin
        // Each clear keeps the back end sweeping for a whole pass of the fine
        // store, after any clear already waiting ahead of it.
        if (cmd_e'(command_i) == CMD_CLEAR) begin
          sweep_wait += FineDepth + DrainCycles;
        end
        if (predict_histogram_op(cmd_e'(command_i), pixel_value_i, mask_value_i,
                                 fine_index_i, coarse_index_i, want)) begin
          expected_readouts.push_back(want);
        end
      end
      // Register writes are followed from the port itself; writes to an
      // address outside the register list are dropped.
      if (psel && penable && pwrite && pready && reg_e'(paddr[2]) == REG_EDGE_LEVEL) begin
        edge_model = pwdata[PixelBits-1:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Command sender
  // --------------------------------------------------------------------------

  // Presents one transaction and returns at the rising edge that accepts it.
  // start is left high so that a following transaction with no gap keeps it
  // high; the idle cycles before a transaction carry random junk on the
  // fields to show that the block ignores them.
  task automatic send_command(cmd_e op, logic [15:0] pix, logic [7:0] mask,
                              logic [15:0] fidx, logic [7:0] cidx);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    @(negedge clk_i);
    if (gap != 0) begin
      start          <= 1'b0;
      command_i      <= 2'($urandom_range(0, 3));
      pixel_value_i  <= 16'($urandom_range(0, 65535));
      mask_value_i   <= 8'($urandom_range(0, 255));
      fine_index_i   <= 16'($urandom_range(0, 65535));
      coarse_index_i <= 8'($urandom_range(0, 255));
      repeat (gap) @(negedge clk_i);
    end
    start          <= 1'b1;
    command_i      <= op;
    pixel_value_i  <= pix;
    mask_value_i   <= mask;
    fine_index_i   <= fidx;
    coarse_index_i <= cidx;
    do @(posedge clk_i); while (busy);
  endtask

  // Stops sending, waits for every owed result, for any clear still sweeping
  // and for the back end to go quiet, so that the configuration can be
  // changed safely.
  task automatic wait_until_idle();
    @(negedge clk_i);
    start <= 1'b0;
    while (expected_readouts.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    while (sweep_wait != 0) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_edge_readback();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= EdgeAddr;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    flag_mismatch("edge_level readback", {16'h0000, edge_model}, prdata);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // The upper half of the write data is random: only the low 16 bits are
  // meant to reach the register.
  task automatic set_edge_level(logic [15:0] level);
    wait_until_idle();
    apb_write(EdgeAddr, {16'($urandom_range(0, 65535)), level});
    check_edge_readback();
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  task automatic test_register_access();
    set_edge_level(16'h0000);
    // A write beyond the register list must leave the edge level alone.
    apb_write(UnusedAddr, 32'($urandom));
    check_edge_readback();
    set_edge_level(16'hFFFF);
  endtask

  // Threshold at both ends of the edge range and either side of a middle
  // edge, with the mask fully set, nearly set and clear. The index fields
  // carry all ones, all zeros or a fixed pattern, which must have no effect.
  task automatic test_threshold_cases();
    send_command(CMD_THRESHOLD, 16'hFFFF, FullMask, 16'hFFFF, 8'hFF);
    send_command(CMD_THRESHOLD, 16'hFFFE, FullMask, 16'hFFFF, 8'hFF);
    send_command(CMD_THRESHOLD, 16'hFFFF, 8'hFE, 16'hFFFF, 8'hFF);
    set_edge_level(16'h0000);
    send_command(CMD_THRESHOLD, 16'h0000, FullMask, 16'h0000, 8'h00);
    send_command(CMD_THRESHOLD, 16'h0000, 8'h00, 16'h0000, 8'h00);
    send_command(CMD_THRESHOLD, 16'hFFFF, 8'h7F, 16'h0000, 8'h00);
    set_edge_level(16'h8000);
    send_command(CMD_THRESHOLD, 16'h7FFF, FullMask, 16'h5A5A, 8'hA5);
    send_command(CMD_THRESHOLD, 16'h8000, FullMask, 16'h5A5A, 8'hA5);
    send_command(CMD_THRESHOLD, 16'h8001, 8'h80, 16'h5A5A, 8'hA5);
  endtask

  // Accumulates at the extreme bins and the same bin back to back, so the
  // block has to forward an update that has not reached its store yet.
  // An unmasked pixel must not be counted. A saturated count cannot be
  // reached with 32-bit counters in a run of this length.
  task automatic test_accumulate_and_read();
    no_idle = 1'b1;
    send_command(CMD_ACCUMULATE, 16'h0000, FullMask, 16'hFFFF, 8'hFF);
    send_command(CMD_ACCUMULATE, 16'hFFFF, FullMask, 16'h0000, 8'h00);
    send_command(CMD_ACCUMULATE, 16'hFFFF, FullMask, 16'h0000, 8'h00);
    send_command(CMD_ACCUMULATE, 16'h1234, 8'hFE, 16'h0000, 8'h00);
    send_command(CMD_READ, 16'hFFFF, 8'h00, 16'h0000, 8'h00);
    send_command(CMD_READ, 16'h0000, FullMask, 16'hFFFF, 8'hFF);
    send_command(CMD_READ, 16'h0000, 8'h00, 16'h1234, 8'h12);
    send_command(CMD_ACCUMULATE, 16'h1234, FullMask, 16'h0000, 8'h00);
    send_command(CMD_READ, 16'h0000, 8'h00, 16'h1234, 8'h12);
    no_idle = 1'b0;
  endtask

  task automatic test_clear();
    send_command(CMD_CLEAR, 16'hFFFF, FullMask, 16'hFFFF, 8'hFF);
    send_command(CMD_READ, 16'h0000, 8'h00, 16'hFFFF, 8'hFF);
    send_command(CMD_READ, 16'h0000, 8'h00, 16'h1234, 8'h12);
  endtask

  // Random traffic in phases, each with its own edge level. Pixels mostly
  // come from a small pool so that bins repeat, reads mostly target the bin
  // of their own pixel value, and clears are rare because each one keeps
  // the block busy for a whole sweep of the fine store.
  task automatic test_random_traffic();
    logic [15:0] edges [RandomPhases];
    logic [15:0] pixel_pool [8];
    logic [15:0] pix;
    logic [15:0] fidx;
    logic [7:0]  mask;
    logic [7:0]  cidx;
    int unsigned roll;
    cmd_e        op;
    edges = '{16'($urandom_range(1, 65534)), 16'h0000, 16'hFFFF, 16'h8000,
              16'($urandom_range(0, 65535))};
    for (int ph = 0; ph < RandomPhases; ph++) begin
      set_edge_level(edges[ph]);
      foreach (pixel_pool[i]) pixel_pool[i] = 16'($urandom_range(0, 65535));
      for (int n = 0; n < PhaseItems; n++) begin
        // Stretches of back-to-back traffic alternate with gapped traffic.
        if (n % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);

        roll = $urandom_range(0, 199);
        if (roll < 90) op = CMD_ACCUMULATE;
        else if (roll < 130) op = CMD_THRESHOLD;
        else if (roll < 199 || clears_left == 0) op = CMD_READ;
        else begin
          op = CMD_CLEAR;
          clears_left--;
        end

        case ($urandom_range(0, 9))
          0:       pix = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
          1, 2, 3: pix = 16'($urandom_range(0, 65535));
          default: pix = pixel_pool[$urandom_range(0, 7)];
        endcase
        // Thresholds often land right on or next to the edge.
        if (op == CMD_THRESHOLD && $urandom_range(0, 1) == 0) begin
          pix = edges[ph] + 16'($urandom_range(0, 2)) - 16'd1;
        end
        mask = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : FullMask;

        if (op == CMD_READ && $urandom_range(0, 2) != 0) begin
          fidx = pix;
          cidx = pix[15:8];
        end else begin
          fidx = 16'($urandom_range(0, 65535));
          cidx = 8'($urandom_range(0, 255));
        end
        send_command(op, pix, mask, fidx, cidx);
      end
    end
    no_idle = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni         = 1'b0;
    start          = 1'b0;
    command_i      = CMD_ACCUMULATE;
    pixel_value_i  = '0;
    mask_value_i   = '0;
    fine_index_i   = '0;
    coarse_index_i = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    fail_count     = 0;
    clears_left    = MaxRandomClears;
    sweep_wait     = 0;
    no_idle        = 1'b0;
    edge_model     = '0;
    wipe_histograms();

    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // The sweep that follows reset holds busy high; the first register
    // access waits for it to finish.
    test_register_access();
    test_threshold_cases();
    test_accumulate_and_read();
    test_clear();
    test_random_traffic();
    wait_until_idle();

    if (fail_count == 0) begin
      $display("masked_histogram_threshold: match");
    end else begin
      $display("masked_histogram_threshold: mismatch");
    end
    $finish;
  end

  // The slowest correct run is mostly the reset sweep and five clears; this
  // timeout allows several times that.
  initial begin
    #10_000_000;
    $display("masked_histogram_threshold: mismatch");
    $finish;
  end

endmodule
